// ===== rtl/core/pidfd_pkg.sv =====
// pidfd_pkg: types, register indexes and fixed-point helpers for the
// filtered-derivative pid controller; no dependencies
package pidfd_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned DIV_STEPS = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_KP          = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KI          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KD          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TAU         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_TIME = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LIM_MIN     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LIM_MAX     = 3'd6;

   localparam logic [4:0] SH_Q16 = 5'd16;
   localparam logic [4:0] SH_Q15 = 5'd15;
   localparam logic [4:0] SH_Q17 = 5'd17;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   typedef enum logic [11:0] {
      ST_IDLE = 12'b0000_0000_0001,
      ST_ERR  = 12'b0000_0000_0010,
      ST_M_P  = 12'b0000_0000_0100,
      ST_M_KT = 12'b0000_0000_1000,
      ST_M_A  = 12'b0000_0001_0000,
      ST_M_I  = 12'b0000_0010_0000,
      ST_M_B  = 12'b0000_0100_0000,
      ST_INT  = 12'b0000_1000_0000,
      ST_NUM  = 12'b0001_0000_0000,
      ST_DIV  = 12'b0010_0000_0000,
      ST_FIN  = 12'b0100_0000_0000,
      ST_SUM  = 12'b1000_0000_0000
   } state_type;

   // saturate a 34 bit signed value to 32 bits
   function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (!v[33] && v[32:31] != 2'b00) begin
         r = Q_MAX;
      end else if (v[33] && v[32:31] != 2'b11) begin
         r = Q_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // magnitude of a 33 bit two's complement value
   function automatic logic [32:0] mag33(input logic [32:0] v);
      logic [32:0] r;
      r = v[32] ? (~v + 33'd1) : v;
      return r;
   endfunction

   // round half away from zero after the shift, then apply sign and saturate
   function automatic logic signed [31:0] round_sat(input logic [65:0] prod,
                                                    input logic [4:0]  sh,
                                                    input logic        neg);
      logic [65:0] sum;
      logic [65:0] q;
      logic signed [31:0] r;
      sum = prod + (66'd1 << (sh - 5'd1));
      q   = sum >> sh;
      if (neg) begin
         if (q >= 66'h0_8000_0000) begin
            r = Q_MIN;
         end else begin
            r = -$signed({1'b0, q[30:0]});
         end
      end else begin
         if (q > 66'h0_7FFF_FFFF) begin
            r = Q_MAX;
         end else begin
            r = $signed(q[31:0]);
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/pid_controller_filtered_derivative_unit.sv =====
// pid_controller_filtered_derivative_unit: pid controller top level with
// anti-windup integrator and low-passed derivative on the measurement
// depends on pidfd_pkg
//
// sequence: rsp_valid and req_ready rise in the same cycle once a word is done,
// so a new word is taken only after the last one's drive is set; the steps are
// one shared 33x33 multiplier used five times and a radix-2 divider taking 32
// steps, skipped when 2*tau + sample_time is zero; a drive word not yet taken
// holds the final sum until rsp_ready
// reset: synchronous, clears configuration registers, controller state and the output word
module pid_controller_filtered_derivative_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [pidfd_pkg::DATA_W-1:0] req_setpoint,
   input  logic signed [pidfd_pkg::DATA_W-1:0] req_measurement,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pidfd_pkg::DATA_W-1:0] rsp_drive,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pidfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pidfd_pkg::DATA_W-1:0]        csr_data
);

   pidfd_pkg::state_type state_ff, state_in;

   // configuration
   logic signed [31:0] kp_ff, kp_in;
   logic signed [31:0] ki_ff, ki_in;
   logic signed [31:0] kd_ff, kd_in;
   logic [30:0]        tau_ff, tau_in;
   logic [30:0]        st_ff, st_in;
   logic signed [31:0] lim_min_ff, lim_min_in;
   logic signed [31:0] lim_max_ff, lim_max_in;

   // controller state
   logic signed [31:0] isum_ff, isum_in;
   logic signed [31:0] last_err_ff, last_err_in;
   logic signed [31:0] last_meas_ff, last_meas_in;
   logic signed [31:0] fd_ff, fd_in;

   // output word
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_drive_ff, rsp_drive_in;

   // working registers
   logic signed [31:0] sp_ff, sp_in;
   logic signed [31:0] ms_ff, ms_in;
   logic signed [31:0] e_ff, e_in;
   logic signed [31:0] dm_ff, dm_in;
   logic signed [32:0] es_ff, es_in;
   logic signed [31:0] p_ff, p_in;
   logic signed [31:0] kt_ff, kt_in;
   logic signed [31:0] a_ff, a_in;
   logic signed [31:0] b_ff, b_in;
   logic signed [31:0] it_ff, it_in;
   logic [65:0]        prod_ff, prod_in;
   logic               mneg_ff, mneg_in;

   // divider
   logic [32:0]        rem_ff, rem_in;
   logic [31:0]        lo_ff, lo_in;
   logic [31:0]        quo_ff, quo_in;
   logic               ovf_ff, ovf_in;
   logic               dneg_ff, dneg_in;
   logic [4:0]         cnt_ff, cnt_in;

   // shared multiplier
   logic [32:0]        op_a;
   logic [32:0]        op_b;
   logic [32:0]        mag_a;
   logic [32:0]        mag_b;

   logic signed [32:0] coef;
   logic [32:0]        den;
   logic               den_zero;
   logic [4:0]         rshift;
   logic signed [31:0] rnd;
   logic signed [31:0] e_c;
   logic signed [31:0] win_hi;
   logic signed [31:0] win_lo;
   logic signed [31:0] num_c;
   logic [32:0]        num_mag;
   logic [48:0]        dividend;
   logic [33:0]        trial;
   logic               qbit;
   logic               q_ovf;
   logic signed [31:0] drive_c;

   assign coef     = $signed({1'b0, tau_ff, 1'b0}) - $signed({2'b00, st_ff});
   assign den      = {1'b0, tau_ff, 1'b0} + {2'b00, st_ff};
   assign den_zero = (den == 33'd0);

   assign req_ready = (state_ff == pidfd_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;
   assign csr_ready = 1'b1;

   // operand select for the shared multiplier
   always_comb begin
      op_a = {kp_ff[31], kp_ff};
      op_b = {e_ff[31], e_ff};
      case (state_ff)
         pidfd_pkg::ST_M_KT: begin
            op_a = {ki_ff[31], ki_ff};
            op_b = {2'b00, st_ff};
         end
         pidfd_pkg::ST_M_A: begin
            op_a = {kd_ff[31], kd_ff};
            op_b = {dm_ff[31], dm_ff};
         end
         pidfd_pkg::ST_M_I: begin
            op_a = {kt_ff[31], kt_ff};
            op_b = es_ff;
         end
         pidfd_pkg::ST_M_B: begin
            op_a = coef;
            op_b = {fd_ff[31], fd_ff};
         end
         default: begin
            op_a = {kp_ff[31], kp_ff};
            op_b = {e_ff[31], e_ff};
         end
      endcase
   end

   assign mag_a   = pidfd_pkg::mag33(op_a);
   assign mag_b   = pidfd_pkg::mag33(op_b);
   assign prod_in = mag_a * mag_b;
   assign mneg_in = op_a[32] ^ op_b[32];

   // rounding shift applied to the product of the previous step
   always_comb begin
      case (state_ff)
         pidfd_pkg::ST_M_I: rshift = pidfd_pkg::SH_Q15;
         pidfd_pkg::ST_M_B: rshift = pidfd_pkg::SH_Q17;
         default:           rshift = pidfd_pkg::SH_Q16;
      endcase
   end

   assign rnd = pidfd_pkg::round_sat(prod_ff, rshift, mneg_ff);

   assign e_c = pidfd_pkg::sat34(34'(sp_ff) - 34'(ms_ff));

   // anti-windup window
   assign win_hi = (lim_max_ff > p_ff) ? pidfd_pkg::sat34(34'(lim_max_ff) - 34'(p_ff))
                                       : 32'sd0;
   assign win_lo = (lim_min_ff < p_ff) ? pidfd_pkg::sat34(34'(lim_min_ff) - 34'(p_ff))
                                       : 32'sd0;

   // derivative numerator and rounded dividend
   assign num_c    = pidfd_pkg::sat34(34'(b_ff) - 34'(a_ff));
   assign num_mag  = pidfd_pkg::mag33({num_c[31], num_c});
   assign dividend = 49'({num_mag[31:0], 16'h0000}) + 49'(den[32:1]);

   // one restoring division step
   assign trial = {rem_ff, lo_ff[31]};
   assign qbit  = (trial >= {1'b0, den});
   assign q_ovf = ovf_ff | quo_ff[31];

   assign drive_c = pidfd_pkg::sat34(34'(p_ff) + 34'(isum_ff) + 34'(fd_ff));

   always_comb begin
      state_in     = state_ff;
      kp_in        = kp_ff;
      ki_in        = ki_ff;
      kd_in        = kd_ff;
      tau_in       = tau_ff;
      st_in        = st_ff;
      lim_min_in   = lim_min_ff;
      lim_max_in   = lim_max_ff;
      isum_in      = isum_ff;
      last_err_in  = last_err_ff;
      last_meas_in = last_meas_ff;
      fd_in        = fd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      sp_in        = sp_ff;
      ms_in        = ms_ff;
      e_in         = e_ff;
      dm_in        = dm_ff;
      es_in        = es_ff;
      p_in         = p_ff;
      kt_in        = kt_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      it_in        = it_ff;
      rem_in       = rem_ff;
      lo_in        = lo_ff;
      quo_in       = quo_ff;
      ovf_in       = ovf_ff;
      dneg_in      = dneg_ff;
      cnt_in       = cnt_ff;

      if (csr_valid) begin
         unique case (csr_index)
            pidfd_pkg::CSR_KP:          kp_in      = csr_data;
            pidfd_pkg::CSR_KI:          ki_in      = csr_data;
            pidfd_pkg::CSR_KD:          kd_in      = csr_data;
            pidfd_pkg::CSR_TAU:         tau_in     = csr_data[30:0];
            pidfd_pkg::CSR_SAMPLE_TIME: st_in      = csr_data[30:0];
            pidfd_pkg::CSR_LIM_MIN:     lim_min_in = csr_data;
            pidfd_pkg::CSR_LIM_MAX:     lim_max_in = csr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         pidfd_pkg::ST_IDLE: begin
            if (req_valid) begin
               sp_in    = req_setpoint;
               ms_in    = req_measurement;
               state_in = pidfd_pkg::ST_ERR;
            end
         end
         pidfd_pkg::ST_ERR: begin
            e_in         = e_c;
            es_in        = 33'(e_c) + 33'(last_err_ff);
            dm_in        = pidfd_pkg::sat34(34'(ms_ff) - 34'(last_meas_ff));
            last_err_in  = e_c;
            last_meas_in = ms_ff;
            state_in     = pidfd_pkg::ST_M_P;
         end
         pidfd_pkg::ST_M_P: begin
            state_in = pidfd_pkg::ST_M_KT;
         end
         pidfd_pkg::ST_M_KT: begin
            p_in     = rnd;
            state_in = pidfd_pkg::ST_M_A;
         end
         pidfd_pkg::ST_M_A: begin
            kt_in    = rnd;
            state_in = pidfd_pkg::ST_M_I;
         end
         pidfd_pkg::ST_M_I: begin
            a_in     = rnd;
            state_in = pidfd_pkg::ST_M_B;
         end
         pidfd_pkg::ST_M_B: begin
            it_in    = rnd;
            state_in = pidfd_pkg::ST_INT;
         end
         pidfd_pkg::ST_INT: begin
            b_in     = rnd;
            isum_in  = pidfd_pkg::sat34(34'(isum_ff) + 34'(it_ff));
            state_in = pidfd_pkg::ST_NUM;
         end
         pidfd_pkg::ST_NUM: begin
            if (isum_ff > win_hi) begin
               isum_in = win_hi;
            end else if (isum_ff < win_lo) begin
               isum_in = win_lo;
            end
            dneg_in = num_c[31];
            rem_in  = {16'h0000, dividend[48:32]};
            lo_in   = dividend[31:0];
            ovf_in  = ({16'h0000, dividend[48:32]} >= den);
            quo_in  = '0;
            cnt_in  = 5'(pidfd_pkg::DIV_STEPS - 1);
            state_in = den_zero ? pidfd_pkg::ST_FIN : pidfd_pkg::ST_DIV;
         end
         pidfd_pkg::ST_DIV: begin
            rem_in = qbit ? 33'(trial - {1'b0, den}) : trial[32:0];
            lo_in  = {lo_ff[30:0], 1'b0};
            quo_in = {quo_ff[30:0], qbit};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = pidfd_pkg::ST_FIN;
            end
         end
         pidfd_pkg::ST_FIN: begin
            if (den_zero) begin
               fd_in = 32'sd0;
            end else if (q_ovf) begin
               fd_in = dneg_ff ? pidfd_pkg::Q_MIN : pidfd_pkg::Q_MAX;
            end else if (dneg_ff) begin
               fd_in = -$signed({1'b0, quo_ff[30:0]});
            end else begin
               fd_in = $signed(quo_ff);
            end
            state_in = pidfd_pkg::ST_SUM;
         end
         pidfd_pkg::ST_SUM: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (drive_c > lim_max_ff) begin
                  rsp_drive_in = lim_max_ff;
               end else if (drive_c < lim_min_ff) begin
                  rsp_drive_in = lim_min_ff;
               end else begin
                  rsp_drive_in = drive_c;
               end
               rsp_valid_in = 1'b1;
               state_in     = pidfd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pidfd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pidfd_pkg::ST_IDLE;
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         tau_ff       <= '0;
         st_ff        <= '0;
         lim_min_ff   <= '0;
         lim_max_ff   <= '0;
         isum_ff      <= '0;
         last_err_ff  <= '0;
         last_meas_ff <= '0;
         fd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_drive_ff <= '0;
      end else begin
         state_ff     <= state_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         tau_ff       <= tau_in;
         st_ff        <= st_in;
         lim_min_ff   <= lim_min_in;
         lim_max_ff   <= lim_max_in;
         isum_ff      <= isum_in;
         last_err_ff  <= last_err_in;
         last_meas_ff <= last_meas_in;
         fd_ff        <= fd_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_drive_ff <= rsp_drive_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      sp_ff   <= sp_in;
      ms_ff   <= ms_in;
      e_ff    <= e_in;
      dm_ff   <= dm_in;
      es_ff   <= es_in;
      p_ff    <= p_in;
      kt_ff   <= kt_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      it_ff   <= it_in;
      prod_ff <= prod_in;
      mneg_ff <= mneg_in;
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      quo_ff  <= quo_in;
      ovf_ff  <= ovf_in;
      dneg_ff <= dneg_in;
      cnt_ff  <= cnt_in;
   end

endmodule
